// ----- sv/vertex_transform_perspective_divide_core_macros.svh -----
// Assertion macros for the vertex transform core checker
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_CORE_MACROS_SVH
// Implication checked every clock outside reset
`define VTPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked every clock outside reset
`define VTPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/vtpd_pkg.sv -----
// Shared types and constants for the vertex transform core
package vtpd_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // vertex word passed from front to back: four saturated products and flag
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [31:0] tw;
    logic               sat;
  } prod_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_DIV  = 3'd1,
    BK_NEXT = 3'd2,
    BK_OUT  = 3'd3
  } bk_state_t;
endpackage

// ----- sv/vtpd_front.sv -----
// Front end: matrix store, load handling and row products
module vtpd_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [1:0]          coef_row,
  input  logic [1:0]          coef_col,
  input  logic signed [31:0]  coef_value,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic signed [31:0]  in_w,
  output logic                q_valid,
  input  logic                q_ready,
  output vtpd_pkg::prod_t     q_data
);
  import vtpd_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] mat [16];
  logic signed [31:0] vec [4];
  logic               busy;
  logic [1:0]         row;
  logic signed [31:0] tr [4];
  logic               sat;
  logic signed [65:0] psum;
  logic signed [65:0] pshift;
  logic               rsat;
  logic signed [31:0] rval;
  logic               done;

  assign in_ready = !busy && !done;

  // Row product: four multiplies summed, floor shift, saturate
  always_comb begin
    psum = 66'(mat[{row, 2'd0}] * vec[0]) + 66'(mat[{row, 2'd1}] * vec[1])
         + 66'(mat[{row, 2'd2}] * vec[2]) + 66'(mat[{row, 2'd3}] * vec[3]);
    pshift = psum >>> FRAC_BITS;
    rsat = (pshift > 66'sd2147483647) || (pshift < -66'sd2147483648);
    if (pshift > 66'sd2147483647) begin
      rval = 32'sh7fffffff;
    end else if (pshift < -66'sd2147483648) begin
      rval = 32'sh80000000;
    end else begin
      rval = pshift[31:0];
    end
  end

  // Matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= (i % 5 == 0) ? ONE : 32'sd0;
      end
    end else if (in_valid && in_ready && !kind) begin
      mat[{coef_row, coef_col}] <= coef_value;
    end
  end

  // Iterate one row per cycle, then hand the word to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      row  <= 2'd0;
      sat  <= 1'b0;
    end else if (in_valid && in_ready && kind) begin
      busy <= 1'b1;
      row  <= 2'd0;
      sat  <= 1'b0;
      vec[0] <= in_x;
      vec[1] <= in_y;
      vec[2] <= in_z;
      vec[3] <= in_w;
    end else if (busy) begin
      tr[row] <= rval;
      sat     <= sat | rsat;
      row     <= row + 2'd1;
      if (row == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (done && q_ready) begin
      done <= 1'b0;
    end
  end

  assign q_valid = done;
  assign q_data  = '{tx: tr[0], ty: tr[1], tz: tr[2], tw: tr[3], sat: sat};
endmodule

// ----- sv/vtpd_queue.sv -----
// Short queue between front and back
module vtpd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  vtpd_pkg::prod_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output vtpd_pkg::prod_t rd_data
);
  import vtpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  prod_t           mem [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [AW:0]     cnt;
  logic            wr;
  logic            rd;

  assign wr_ready = cnt != (AW+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ----- sv/vtpd_divider.sv -----
// Radix-2 restoring divider for (t << FRAC_BITS) / tw with saturation
module vtpd_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot,
  output logic               sat
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [32:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          run;
  logic [33:0]   trial;
  logic [NW:0]   mag;
  logic [NW:0]   qfull;
  logic [32:0]   nmag;

  assign trial = {rem, dvd[NW-1]} - {2'b0, dvs};

  // Magnitude of the signed numerator
  assign nmag = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
        neg <= num[31] ^ den[31];
        dvd <= NW'(nmag) << FRAC_BITS;
        dvs <= den[31] ? 32'(-den) : den;
        rem <= '0;
      end else if (run) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          dvd <= {dvd[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dvd[NW-1]};
          dvd <= {dvd[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign and saturate the magnitude
  always_comb begin
    mag   = {1'b0, dvd};
    qfull = neg ? -mag : mag;
    if (!neg && mag > (NW+1)'(32'h7fffffff)) begin
      quot = 32'sh7fffffff;
      sat  = 1'b1;
    end else if (neg && mag > (NW+1)'(33'h80000000)) begin
      quot = 32'sh80000000;
      sat  = 1'b1;
    end else begin
      quot = qfull[31:0];
      sat  = 1'b0;
    end
  end
endmodule

// ----- sv/vtpd_back.sv -----
// Back end: three divisions on one divider (none for zero w) and the output register
module vtpd_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  vtpd_pkg::prod_t     q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [1:0]          status
);
  import vtpd_pkg::*;

  bk_state_t          state;
  bk_state_t          state_next;
  prod_t              cur;
  logic [1:0]         comp;
  logic               sat;
  logic signed [31:0] res [3];
  logic               dv_start;
  logic signed [31:0] dv_num;
  logic               dv_done;
  logic signed [31:0] dv_quot;
  logic               dv_sat;
  logic               take;

  vtpd_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(cur.tw),
    .done(dv_done), .quot(dv_quot), .sat(dv_sat)
  );

  always_comb begin
    case (comp)
      2'd0:    dv_num = cur.tx;
      2'd1:    dv_num = cur.ty;
      default: dv_num = cur.tz;
    endcase
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    q_ready  = 1'b0;
    dv_start = 1'b0;
    take     = 1'b0;
    case (state)
      BK_IDLE: begin
        q_ready = !out_valid || out_ready;
        if (q_valid && q_ready) begin
          take = 1'b1;
          state_next = (q_data.tw == 32'sd0) ? BK_IDLE : BK_NEXT;
        end
      end
      BK_NEXT: begin
        dv_start = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        if (dv_done) state_next = (comp == 2'd2) ? BK_OUT : BK_NEXT;
      end
      BK_OUT: begin
        if (!out_valid || out_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // zero w finishes at once
      if (take && q_data.tw == 32'sd0) begin
        out_valid <= 1'b1;
        out_x  <= '0;
        out_y  <= '0;
        out_z  <= '0;
        status <= ST_ZERO;
      end else if (state == BK_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        out_x  <= res[0];
        out_y  <= res[1];
        out_z  <= res[2];
        status <= sat ? ST_SAT : ST_OK;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the word and collect quotients
  always_ff @(posedge clk) begin
    if (take) begin
      cur  <= q_data;
      sat  <= q_data.sat;
      comp <= 2'd0;
    end else if (state == BK_DIV && dv_done) begin
      res[comp] <= dv_quot;
      sat       <= sat | dv_sat;
      comp      <= comp + 2'd1;
    end
  end
endmodule

// ----- sv/vertex_transform_perspective_divide_core.sv -----
// A vertex passes the row products, the queue and three divisions; zero w skips the divisions.
// Each division: a start from BK_NEXT, 32+FRAC_BITS restoring steps, then the done strobe.
// The back end takes a new vertex only after its divisions on the shared divider are through.
// After a vertex the input stalls for the row products and until the queue takes the word.
// Reset (synchronous, active high) loads the identity matrix and empties all stages.
module vertex_transform_perspective_divide_core #(
  parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [1:0]         coef_row,
  input  logic [1:0]         coef_col,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [1:0]         status
);
  import vtpd_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  prod_t f_data, b_data;

  vtpd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .coef_row(coef_row), .coef_col(coef_col), .coef_value(coef_value),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  vtpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  vtpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
  );
endmodule

// ----- sv/vtpd_checker.sv -----
// Port-level checker for the vertex transform core, with its bind
`include "vertex_transform_perspective_divide_core_macros.svh"
module vtpd_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x,
  input logic [1:0]         status
);
  import vtpd_pkg::*;
  `VTPD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_x), "result dropped while stalled")
  `VTPD_ASSERT_IMP(a_status_code, clk, rst, out_valid, status != 2'd3, "bad status code")
  `VTPD_ASSERT_IMP(a_zero_out, clk, rst, out_valid && status == ST_ZERO, out_x == 32'sd0, "zero-w result not zero")
endmodule

bind vertex_transform_perspective_divide_core vtpd_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .out_x(out_x), .status(status)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the vertex transform and perspective divide core
`timescale 1ns / 1ps
module tb_top;
  import vtpd_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_XFORM = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = KIND_LOAD;
  logic [1:0] coef_row = '0;
  logic [1:0] coef_col = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [1:0] status;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_t st;
  } vertex_res_t;

  logic signed [31:0] mat [16];
  vertex_res_t pending_verts[$];
  int errors = 0;
  int cycles = 0;
  bit idle_en = 1'b1;

  vertex_transform_perspective_divide_core u_dut (.*);

  always #10 clk = ~clk;

  // Abort the run on a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Saturate a wide value to 32 bits and note it
  function automatic logic signed [31:0] clip32(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Project one vertex through the current matrix
  function automatic vertex_res_t project_vertex(logic signed [31:0] v [4]);
    logic signed [127:0] acc;
    logic signed [127:0] num;
    logic signed [31:0] t [4];
    logic signed [31:0] q [3];
    vertex_res_t r;
    bit sat;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int c = 0; c < 4; c++)
        acc += 128'(mat[i*4+c]) * 128'(v[c]);
      t[i] = clip32(acc >>> FB, sat);
    end
    if (t[3] == 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.st = ST_ZERO;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      num = 128'(t[i]) <<< FB;
      q[i] = clip32(num / 128'(t[3]), sat);
    end
    r.x = q[0]; r.y = q[1]; r.z = q[2];
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Drive one word and update the prediction on acceptance
  task automatic send_word(logic k, logic [1:0] row, logic [1:0] col,
                           logic signed [31:0] cv, logic signed [31:0] vx,
                           logic signed [31:0] vy, logic signed [31:0] vz,
                           logic signed [31:0] vw);
    logic signed [31:0] v [4];
    while (idle_en && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k; coef_row <= row; coef_col <= col; coef_value <= cv;
    in_x <= vx; in_y <= vy; in_z <= vz; in_w <= vw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k == KIND_LOAD) begin
      mat[{row, col}] = cv;
    end else begin
      v[0] = vx; v[1] = vy; v[2] = vz; v[3] = vw;
      pending_verts.push_back(project_vertex(v));
    end
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, logic signed [31:0] vw);
    send_word(KIND_XFORM, 2'($urandom), 2'($urandom), $urandom, vx, vy, vz, vw);
  endtask

  task automatic send_coef(logic [1:0] row, logic [1:0] col, logic signed [31:0] cv);
    send_word(KIND_LOAD, row, col, cv, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Drop valid and hold until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_verts.size() != 0) @(negedge clk);
  endtask

  // Ready toggling on the result side
  always @(negedge clk) out_ready <= !(idle_en && $urandom_range(99) < 17);

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    vertex_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_verts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h st=%0d", $time, out_x, out_y,
                 out_z, status);
        errors++;
      end else begin
        e = pending_verts.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x exp %h got %h", $time, e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y exp %h got %h", $time, e.y, out_y); errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z exp %h got %h", $time, e.z, out_z); errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status); errors++;
        end
      end
    end
  end

  // Identity matrix, extremes, zero w, saturation, then coefficient loads and identity again
  task automatic test_directed();
    send_vertex(32'sd1 << FB, 32'sd2 << FB, -(32'sd3 << FB), 32'sd1 << FB);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sd1 << FB);
    send_vertex(32'sd5 << FB, 32'sd5, 32'sd5, 32'sd0);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sd1, 32'sd1);
    send_vertex(-32'sd1, -32'sd1, -32'sd1, 32'sh80000000);
    send_vertex(32'sd1, 32'sd1, 32'sd1, 32'sd3);
    send_coef(2'd3, 2'd3, 32'sh7fffffff);
    send_coef(2'd0, 2'd0, 32'sh80000000);
    send_coef(2'd3, 2'd0, 32'sd1 << FB);
    send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_vertex(-(32'sd1 << FB), 32'sd1, 32'sd1, 32'sd0);
    send_vertex(32'sd7 << FB, -(32'sd9 << FB), 32'sd3, 32'sd2 << FB);
    // pause until all results are back
    drain();
    for (int i = 0; i < 16; i++)
      send_coef(2'(i / 4), 2'(i % 4), (i % 5 == 0) ? (32'sd1 << FB) : 32'sd0);
    send_vertex(32'sd4 << FB, 32'sd2 << FB, 32'sd1 << FB, 32'sd2 << FB);
  endtask

  // Vertex bursts, some after random coefficient writes
  task automatic test_random(int n_words);
    int sent;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 20) begin
        for (int k = $urandom_range(1, 6); k > 0; k--) begin
          send_coef(2'($urandom), 2'($urandom), rnd_val());
          sent++;
        end
      end
      for (int k = $urandom_range(1, 8); k > 0; k--) begin
        send_vertex(rnd_val(), rnd_val(), rnd_val(),
                    ($urandom_range(9) == 0) ? 32'sd0 : rnd_val());
        sent++;
      end
      if (sent > 600 && sent < 900) idle_en = 1'b0;
      else idle_en = 1'b1;
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? (32'sd1 << FB) : 32'sd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1700);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_verts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/vtpd_pkg.sv
sv/vtpd_front.sv
sv/vtpd_queue.sv
sv/vtpd_divider.sv
sv/vtpd_back.sv
sv/vertex_transform_perspective_divide_core.sv
sv/vtpd_checker.sv
tb/tb_top.sv
